// File: design/stwt_pkg.sv
`default_nettype none
package stwt_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int IDX_W        = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int SCAN_CNT_W   = IDX_W + 1;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 4;
  localparam int DUR_W    = 32;
  localparam int RATE_W   = 14;
  localparam int TIME_W   = 64;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  // ms * rate + 999 needs one bit above the product
  localparam int PROD_W     = DUR_W + RATE_W + 1;
  localparam int MS_PER_S   = 1000;
  localparam int ROUND_UP   = 999;

  // divide by 1000: drop 3 bits, then divide by 125 in two chunks, each through a
  // reciprocal multiply that is exact for inputs below 2^29. The numerator stays
  // below 2^46, so its top bit is never set.
  localparam int DIV_PRE_SH = 3;
  localparam int DIV_ODD    = 125;
  localparam int LO_W       = 22;
  localparam int HI_W       = 21;
  localparam int REM_W      = 7;
  localparam int QHI_W      = 15;
  localparam int QUO_W      = QHI_W + LO_W;
  localparam int RCP_IN_W   = 29;
  localparam int RCP_W      = 30;
  localparam int RCP_SH     = 36;
  localparam int RCP_P_W    = RCP_IN_W + RCP_W;
  localparam int RCP_Q_W    = RCP_P_W - RCP_SH;
  localparam logic [RCP_W-1:0] RCP_MUL = 30'd549755814;

  localparam int DIV_CNT_W  = 2;
  localparam logic [DIV_CNT_W-1:0] DIV_STEP_QHI = 2'd0;
  localparam logic [DIV_CNT_W-1:0] DIV_STEP_REM = 2'd1;
  localparam logic [DIV_CNT_W-1:0] DIV_STEP_QLO = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_TICK        = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SLEEP_TICKS = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SLEEP_MS    = 2'd2;

  typedef struct packed {
    logic capture;
    logic tick;
    logic scan;
    logic mul;
    logic div;
    logic arm;
    logic emit;
  } stwt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic mask_empty;
  } stwt_status_t;

endpackage
`default_nettype wire

// File: design/stwt_ram.sv
`default_nettype none
module stwt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/stwt_dp.sv
`default_nettype none
module stwt_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire stwt_pkg::stwt_cmd_t              cmd,
  output stwt_pkg::stwt_status_t                st,
  input  wire logic [stwt_pkg::ACTION_W-1:0]    action,
  input  wire logic [stwt_pkg::ID_W-1:0]        thread_id,
  input  wire logic [stwt_pkg::DUR_W-1:0]       duration,
  input  wire logic                             cfg_write,
  input  wire logic [stwt_pkg::RATE_W-1:0]      cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [stwt_pkg::ID_W-1:0]             woken_id,
  output logic                                  last
);
  import stwt_pkg::*;

  logic [RATE_W-1:0]       rate;
  logic [TIME_W-1:0]       now;
  logic [ACTION_W-1:0]     act_r;
  logic [ID_W-1:0]         slot_r;
  logic [DUR_W-1:0]        dur_r;
  logic [PROD_W-1:0]       q;
  logic [QHI_W-1:0]        qhi;
  logic [REM_W-1:0]        rem;
  logic [QUO_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic [THREAD_SLOTS-1:0] sleeping;
  logic [THREAD_SLOTS-1:0] mask;
  logic [SCAN_CNT_W-1:0]   scan_cnt;
  logic                    chk_en;
  logic [IDX_W-1:0]        chk_idx;

  logic [PROD_W-1:0]       prod;
  logic [HI_W-1:0]         num_hi;
  logic [RCP_IN_W-1:0]     rcp_in;
  logic [RCP_P_W-1:0]      rcp_prod;
  logic [RCP_Q_W-1:0]      rcp_q;
  logic [HI_W-1:0]         qhi_x;
  logic [REM_W-1:0]        rem_next;
  logic [TIME_W-1:0]       ms_ticks;
  logic [TIME_W-1:0]       arm_ticks;
  logic [TIME_W:0]         sum;
  logic [TIME_W-1:0]       wake_when;
  logic                    slot_ok;
  logic                    arm_we;
  logic [TIME_W-1:0]       rdata;
  logic                    scan_issue;
  logic                    chk_hit;
  logic [IDX_W-1:0]        low_idx;
  logic                    mask_single;
  logic                    out_load;

  stwt_ram #(
    .WIDTH(TIME_W),
    .DEPTH(THREAD_SLOTS)
  ) u_wake_ram (
    .clk  (clk),
    .we   (arm_we),
    .waddr(IDX_W'(slot_r)),
    .wdata(wake_when),
    .raddr(scan_cnt[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    prod = PROD_W'({{(PROD_W - DUR_W){1'b0}}, dur_r} * {{(PROD_W - RATE_W){1'b0}}, rate})
         + PROD_W'(ROUND_UP);

    // high chunk first, then remainder joined with the low chunk
    num_hi   = q[DIV_PRE_SH + LO_W +: HI_W];
    rcp_in   = (div_cnt == DIV_STEP_QLO) ? {rem, q[DIV_PRE_SH +: LO_W]} : RCP_IN_W'(num_hi);
    rcp_prod = RCP_P_W'(rcp_in) * RCP_P_W'(RCP_MUL);
    rcp_q    = rcp_prod[RCP_P_W-1:RCP_SH];
    qhi_x    = HI_W'(qhi) * HI_W'(DIV_ODD);
    rem_next = REM_W'(num_hi - qhi_x);

    ms_ticks  = (quo == '0) ? TIME_W'(1) : TIME_W'(quo);
    arm_ticks = (act_r == ACT_SLEEP_TICKS) ? TIME_W'(dur_r) : ms_ticks;
    sum       = {1'b0, now} + {1'b0, arm_ticks};
    wake_when = (sum[TIME_W] || (sum[TIME_W-1:0] == '0)) ? '1 : sum[TIME_W-1:0];
    slot_ok   = (32'(slot_r) < 32'(THREAD_SLOTS));
    arm_we    = cmd.arm && slot_ok && (arm_ticks != '0);

    scan_issue = cmd.scan && (scan_cnt < SCAN_CNT_W'(THREAD_SLOTS));
    chk_hit    = chk_en && sleeping[chk_idx] && (now >= rdata);

    low_idx = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_idx = IDX_W'(i);
      end
    end
    mask_single = ((mask & (mask - THREAD_SLOTS'(1))) == '0);
    out_load    = cmd.emit && (mask != '0) && (!out_valid || !out_stall);

    st.scan_done  = chk_en && (chk_idx == IDX_W'(THREAD_SLOTS - 1));
    st.div_done   = cmd.div && (div_cnt == DIV_STEP_QLO);
    st.mask_empty = (mask == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate      <= RATE_RESET;
      now       <= '0;
      sleeping  <= '0;
      mask      <= '0;
      scan_cnt  <= '0;
      chk_en    <= 1'b0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        rate <= cfg_data;
      end
      if (cmd.tick) begin
        now      <= now + TIME_W'(1);
        scan_cnt <= '0;
      end else if (scan_issue) begin
        scan_cnt <= scan_cnt + SCAN_CNT_W'(1);
      end
      chk_en <= scan_issue;
      if (cmd.mul) begin
        div_cnt <= '0;
      end else if (cmd.div) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (arm_we) begin
        sleeping[IDX_W'(slot_r)] <= 1'b1;
      end
      if (chk_hit) begin
        sleeping[chk_idx] <= 1'b0;
        mask[chk_idx]     <= 1'b1;
      end
      if (out_load) begin
        mask[low_idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= action;
      slot_r <= thread_id;
      dur_r  <= duration;
    end
    if (cmd.mul) begin
      q <= prod;
    end else if (cmd.div) begin
      case (div_cnt)
        DIV_STEP_QHI: begin
          qhi <= rcp_q[QHI_W-1:0];
        end
        DIV_STEP_REM: begin
          rem <= rem_next;
        end
        DIV_STEP_QLO: begin
          quo <= {qhi, rcp_q[LO_W-1:0]};
        end
        default: begin
        end
      endcase
    end
    chk_idx <= scan_cnt[IDX_W-1:0];
    if (out_load) begin
      woken_id <= ID_W'(low_idx);
      last     <= mask_single;
    end
  end

endmodule
`default_nettype wire

// File: design/stwt_ctrl.sv
`default_nettype none
module stwt_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [stwt_pkg::ACTION_W-1:0] action,
  input  wire stwt_pkg::stwt_status_t        st,
  output stwt_pkg::stwt_cmd_t                cmd
);
  import stwt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TICK = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_EMIT = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_ARM  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_TICK:        state_next = S_TICK;
            ACT_SLEEP_TICKS: state_next = S_ARM;
            ACT_SLEEP_MS:    state_next = S_MUL;
            default:         state_next = S_IDLE;
          endcase
        end
      end
      S_TICK: state_next = S_SCAN;
      S_SCAN: begin
        if (st.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.mask_empty) begin
          state_next = S_IDLE;
        end
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_ARM;
        end
      end
      S_ARM:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != S_IDLE);
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.tick    = (state == S_TICK);
    cmd.scan    = (state == S_SCAN);
    cmd.mul     = (state == S_MUL);
    cmd.div     = (state == S_DIV);
    cmd.arm     = (state == S_ARM);
    cmd.emit    = (state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: design/sleep_timer_wakeup_table_unit.sv
// Tick: advance the counter, then scan the 16 slots through the wake-time RAM (one read
//   per cycle, registered read), then emit each woken slot, lowest index first; the emit
//   phase holds while out_stall keeps the output register full. Then the next item is taken.
// Sleep in ticks: arm only. Sleep in ms: multiply, 3-step divide by 1000, arm.
//   Unused action: dropped. One item in flight; results leave through an output register.
// Reset (rst, synchronous): counter and all slots cleared, rate back to 1000.
`default_nettype none
module sleep_timer_wakeup_table_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [stwt_pkg::RATE_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [stwt_pkg::ACTION_W-1:0] action,
  input  wire logic [stwt_pkg::ID_W-1:0]     thread_id,
  input  wire logic [stwt_pkg::DUR_W-1:0]    duration,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stwt_pkg::ID_W-1:0]          woken_id,
  output logic                               last
);
  import stwt_pkg::*;

  stwt_cmd_t    cmd;
  stwt_status_t st;

  stwt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action  (action),
    .st      (st),
    .cmd     (cmd)
  );

  stwt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .action   (action),
    .thread_id(thread_id),
    .duration (duration),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .woken_id (woken_id),
    .last     (last)
  );

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.tick, cmd.scan, cmd.mul, cmd.div, cmd.arm, cmd.emit}))
    else $error("datapath commands overlap");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_TICK) |=> cmd.tick)
    else $error("tick transfer did not start counter update");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_SLEEP_MS) |=> cmd.mul)
    else $error("ms sleep transfer did not start conversion");

  assert property (@(posedge clk) disable iff (rst)
    st.scan_done |=> cmd.emit)
    else $error("scan end did not enter result phase");

endmodule
`default_nettype wire
